// ----- hdl/ggs_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, register codes, angle table and the cell payload type for go-to-goal steering.
package ggs_pkg;

   // Default CORDIC stage count and the length of the arctangent table.
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_LEN          = 24;

   // Field widths.
   localparam int PW  = 16;   // position, Q8.8
   localparam int HW  = 15;   // heading, Q3.12
   localparam int DW  = 17;   // offset and distance
   localparam int EW  = 16;   // heading difference
   localparam int SQW = 32;   // one square
   localparam int XW  = 34;   // CORDIC x / y
   localparam int ZW  = 24;   // CORDIC angle, Q.20
   localparam int RW  = 34;   // root radicand / remainder
   localparam int GW  = 9;    // speed gain
   localparam int SW  = 16;   // speed out
   localparam int TW  = 16;   // turn rate out

   // Square root: 17 digit steps, first trial bit at 2^32.
   localparam int SQ_STEPS = 17;
   localparam int SQ_MSB   = 32;

   localparam int CSR_IW = 2;
   localparam logic [CSR_IW-1:0] CSR_ENABLE = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_RADIUS = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_GAIN   = 2'd2;

   localparam logic        ENABLE_RST = 1'b0;
   localparam logic [15:0] RADIUS_RST = 16'd26;
   localparam logic [GW-1:0] GAIN_RST = 9'd128;

   localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
   localparam logic signed [16:0]   PI_Q12      = 17'sd12868;
   localparam logic signed [16:0]   TWO_PI_Q12  = 17'sd25736;

   localparam logic signed [ZW-1:0] ATAN_Q20 [ATAN_LEN] = '{
      24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451, 24'sd32757,
      24'sd16383,  24'sd8192,   24'sd4096,   24'sd2048,   24'sd1024,  24'sd512,
      24'sd256,    24'sd128,    24'sd64,     24'sd32,     24'sd16,    24'sd8,
      24'sd4,      24'sd2,      24'sd1,      24'sd0,      24'sd0,     24'sd0
   };

   // What travels down the cell row.
   typedef struct packed {
      logic                   zero;     // offset was exactly zero
      logic signed [EW-1:0]   herr;     // target heading minus own heading
      logic signed [HW-1:0]   own_hd;
      logic signed [XW-1:0]   x;
      logic signed [XW-1:0]   y;
      logic signed [ZW-1:0]   z;
      logic [RW-1:0]          rem;
      logic [RW-1:0]          root;
   } ggs_cell_type;

endpackage

// ----- hdl/ggs_front.sv -----
`timescale 1ns / 1ps
// Front stages: offsets, squares with quadrant pre-rotation, radicand sum.
module ggs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [ggs_pkg::PW-1:0] target_x,
   input  logic signed [ggs_pkg::PW-1:0] target_y,
   input  logic signed [ggs_pkg::HW-1:0] target_heading,
   input  logic signed [ggs_pkg::PW-1:0] own_x,
   input  logic signed [ggs_pkg::PW-1:0] own_y,
   input  logic signed [ggs_pkg::HW-1:0] own_heading,
   output logic                          out_valid,
   input  logic                          out_ready,
   output ggs_pkg::ggs_cell_type         out_data
);
   import ggs_pkg::*;

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   logic signed [DW-1:0] dx1_ff, dy1_ff, dx1_in, dy1_in;
   logic signed [EW-1:0] herr1_ff, herr1_in, herr2_ff;
   logic signed [HW-1:0] oh1_ff, oh2_ff;

   logic [SQW-1:0]       sqx2_ff, sqy2_ff, sqx2_in, sqy2_in;
   logic signed [XW-1:0] x2_ff, y2_ff, x2_in, y2_in, xs, ys;
   logic signed [ZW-1:0] z2_ff, z2_in;
   logic                 zero2_ff, zero2_in;
   logic signed [2*DW-1:0] px, py;

   ggs_cell_type s3_ff, s3_in;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // stage 1: offsets
   always_comb begin
      dx1_in   = $signed({target_x[PW-1], target_x}) - $signed({own_x[PW-1], own_x});
      dy1_in   = $signed({target_y[PW-1], target_y}) - $signed({own_y[PW-1], own_y});
      herr1_in = $signed({target_heading[HW-1], target_heading})
               - $signed({own_heading[HW-1], own_heading});
   end

   // stage 2: squares, and a left-half-plane vector turned by a quarter
   always_comb begin
      px = $signed({{DW{dx1_ff[DW-1]}}, dx1_ff}) * $signed({{DW{dx1_ff[DW-1]}}, dx1_ff});
      py = $signed({{DW{dy1_ff[DW-1]}}, dy1_ff}) * $signed({{DW{dy1_ff[DW-1]}}, dy1_ff});
      sqx2_in = px[SQW-1:0];
      sqy2_in = py[SQW-1:0];
      xs = {{(XW-DW-14){dx1_ff[DW-1]}}, dx1_ff, 14'b0};
      ys = {{(XW-DW-14){dy1_ff[DW-1]}}, dy1_ff, 14'b0};
      zero2_in = (dx1_ff == '0) && (dy1_ff == '0);
      if (dx1_ff[DW-1]) begin
         if (!dy1_ff[DW-1]) begin
            x2_in = ys;
            y2_in = -xs;
            z2_in = HALF_PI_Q20;
         end else begin
            x2_in = -ys;
            y2_in = xs;
            z2_in = -HALF_PI_Q20;
         end
      end else begin
         x2_in = xs;
         y2_in = ys;
         z2_in = '0;
      end
   end

   // stage 3: radicand
   always_comb begin
      s3_in.zero   = zero2_ff;
      s3_in.herr   = herr2_ff;
      s3_in.own_hd = oh2_ff;
      s3_in.x      = x2_ff;
      s3_in.y      = y2_ff;
      s3_in.z      = z2_ff;
      s3_in.rem    = RW'({1'b0, sqx2_ff} + {1'b0, sqy2_ff});
      s3_in.root   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         dx1_ff   <= dx1_in;
         dy1_ff   <= dy1_in;
         herr1_ff <= herr1_in;
         oh1_ff   <= own_heading;
      end
      if (rdy2) begin
         sqx2_ff  <= sqx2_in;
         sqy2_ff  <= sqy2_in;
         x2_ff    <= x2_in;
         y2_ff    <= y2_in;
         z2_ff    <= z2_in;
         zero2_ff <= zero2_in;
         herr2_ff <= herr1_ff;
         oh2_ff   <= oh1_ff;
      end
      if (rdy3) s3_ff <= s3_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = s3_ff;

endmodule

// ----- hdl/ggs_cell.sv -----
`timescale 1ns / 1ps
// One cell of the row: a CORDIC vectoring stage and a square-root digit step, each switched on by its own parameter.
module ggs_cell #(
   parameter int IDX     = 0,
   parameter bit DO_ROT  = 1'b1,
   parameter bit DO_SQRT = 1'b1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ggs_pkg::ggs_cell_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ggs_pkg::ggs_cell_type out_data
);
   import ggs_pkg::*;

   localparam int SQ_SHIFT = DO_SQRT ? (SQ_MSB - 2 * IDX) : 0;
   localparam int ROT_IDX  = DO_ROT ? IDX : 0;
   localparam logic [RW-1:0] SQ_BIT = {{(RW-1){1'b0}}, 1'b1} << SQ_SHIFT;

   logic         v_ff;
   ggs_cell_type d_ff, d_in;
   logic signed [XW-1:0] xs, ys;
   logic [RW:0]          trial;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      d_in  = in_data;
      xs    = in_data.x >>> ROT_IDX;
      ys    = in_data.y >>> ROT_IDX;
      trial = {1'b0, in_data.root} + {1'b0, SQ_BIT};
      if (DO_ROT) begin
         if (!in_data.y[XW-1]) begin
            d_in.x = in_data.x + ys;
            d_in.y = in_data.y - xs;
            d_in.z = in_data.z + ATAN_Q20[ROT_IDX];
         end else begin
            d_in.x = in_data.x - ys;
            d_in.y = in_data.y + xs;
            d_in.z = in_data.z - ATAN_Q20[ROT_IDX];
         end
      end
      if (DO_SQRT) begin
         if ({1'b0, in_data.rem} >= trial) begin
            d_in.rem  = in_data.rem - trial[RW-1:0];
            d_in.root = (in_data.root >> 1) + SQ_BIT;
         end else begin
            d_in.root = in_data.root >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) d_ff <= d_in;
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

endmodule

// ----- hdl/ggs_back.sv -----
`timescale 1ns / 1ps
// Back stages: distance test, speed product, bearing rounding, error wrap, output register.
module ggs_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  ggs_pkg::ggs_cell_type         in_data,
   input  logic [15:0]                   arrive_radius,
   input  logic [ggs_pkg::GW-1:0]        speed_gain,
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic [ggs_pkg::SW-1:0]        forward_speed,
   output logic signed [ggs_pkg::TW-1:0] turn_rate,
   output logic                          arrived
);
   import ggs_pkg::*;

   localparam int PRW = GW + DW;

   logic v1_ff, v2_ff, rdy1, rdy2;

   logic [DW-1:0]        dist_q;
   logic signed [ZW-1:0] zr;
   logic                 arr1_ff, arr1_in;
   logic [PRW-1:0]       prod1_ff, prod1_in;
   logic signed [15:0]   bear1_ff, bear1_in;
   logic signed [EW-1:0] herr1_ff;
   logic signed [HW-1:0] oh1_ff;

   logic [PRW-9:0]       spd_raw;
   logic [SW-1:0]        spd2_in, spd2_ff;
   logic signed [16:0]   err, wrapped;
   logic signed [TW-1:0] turn2_ff;
   logic                 arr2_ff;

   assign rdy2     = !v2_ff || !out_stall;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // stage 1
   always_comb begin
      dist_q   = in_data.root[DW-1:0];
      arr1_in  = {1'b0, arrive_radius} > dist_q;
      prod1_in = {{DW{1'b0}}, speed_gain} * {{GW{1'b0}}, dist_q};
      zr       = in_data.z + 24'sd128;
      bear1_in = in_data.zero ? 16'sd0 : zr[ZW-1:8];
   end

   // stage 2: saturate and wrap once
   always_comb begin
      spd_raw = prod1_ff[PRW-1:8];
      spd2_in = (spd_raw[PRW-9:SW] != '0) ? {SW{1'b1}} : spd_raw[SW-1:0];
      if (arr1_ff) begin
         spd2_in = '0;
         err     = {herr1_ff[EW-1], herr1_ff};
      end else begin
         err = {bear1_ff[15], bear1_ff} - {{2{oh1_ff[HW-1]}}, oh1_ff};
      end
      if (err > PI_Q12) begin
         wrapped = err - TWO_PI_Q12;
      end else if (err < -PI_Q12) begin
         wrapped = err + TWO_PI_Q12;
      end else begin
         wrapped = err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         arr1_ff  <= arr1_in;
         prod1_ff <= prod1_in;
         bear1_ff <= bear1_in;
         herr1_ff <= in_data.herr;
         oh1_ff   <= in_data.own_hd;
      end
      if (rdy2) begin
         spd2_ff  <= spd2_in;
         turn2_ff <= wrapped[TW-1:0];
         arr2_ff  <= arr1_ff;
      end
   end

   assign out_valid     = v2_ff;
   assign forward_speed = spd2_ff;
   assign turn_rate     = turn2_ff;
   assign arrived       = arr2_ff;

endmodule

// ----- hdl/go_to_goal_steering_top.sv -----
`timescale 1ns / 1ps
// Top level of the go-to-goal steering controller: config registers and the processing pipeline.
//
//   channel | ports                           | direction | beat content
//   --------+---------------------------------+-----------+------------------------------
//   req     | req_valid / req_stall (out)     | in        | target pose, own pose
//   rsp     | rsp_valid / rsp_stall (in)      | out       | forward speed, turn, arrived
//   csr     | csr_wr_en, csr_index, csr_data  | in        | register write, no read-back
//
// One beat is taken every cycle while req_stall is low; the path is three front stages,
// a row of NCELL = max(17, min(CORDIC_STAGES, 24)) cells and two back stages.
// The row of cells runs the CORDIC angle stages and the square-root digit steps side by side.
// Reset (synchronous) empties the pipeline and loads enable 0, radius 26, gain 128.
// A stall on rsp only freezes stages that are full; bubbles close up, so req stalls only
// when every stage holds a beat.
// Beats taken while output is disabled are dropped at the input.
module go_to_goal_steering_top #(
   parameter int CORDIC_STAGES = ggs_pkg::CORDIC_STAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [ggs_pkg::PW-1:0]     req_target_x,
   input  logic signed [ggs_pkg::PW-1:0]     req_target_y,
   input  logic signed [ggs_pkg::HW-1:0]     req_target_heading,
   input  logic signed [ggs_pkg::PW-1:0]     req_own_x,
   input  logic signed [ggs_pkg::PW-1:0]     req_own_y,
   input  logic signed [ggs_pkg::HW-1:0]     req_own_heading,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ggs_pkg::SW-1:0]            rsp_forward_speed,
   output logic signed [ggs_pkg::TW-1:0]     rsp_turn_rate,
   output logic                              rsp_arrived,
   input  logic                              csr_wr_en,
   input  logic [ggs_pkg::CSR_IW-1:0]        csr_index,
   input  logic [15:0]                       csr_data
);
   import ggs_pkg::*;

   // Stages beyond the angle table add nothing.
   localparam int CSTG  = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
   localparam int NCELL = (CSTG > SQ_STEPS) ? CSTG : SQ_STEPS;

   // configuration
   logic          enable_ff;
   logic [15:0]   radius_ff;
   logic [GW-1:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= ENABLE_RST;
         radius_ff <= RADIUS_RST;
         gain_ff   <= GAIN_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENABLE: enable_ff <= csr_data[0];
            CSR_RADIUS: radius_ff <= csr_data;
            CSR_GAIN:   gain_ff   <= csr_data[GW-1:0];
            default: ;
         endcase
      end
   end

   // front
   logic         front_ready;
   logic         c_valid [NCELL+1];
   logic         c_ready [NCELL+1];
   ggs_cell_type c_data  [NCELL+1];

   assign req_stall = !front_ready;

   ggs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid && enable_ff),
      .in_ready       (front_ready),
      .target_x       (req_target_x),
      .target_y       (req_target_y),
      .target_heading (req_target_heading),
      .own_x          (req_own_x),
      .own_y          (req_own_y),
      .own_heading    (req_own_heading),
      .out_valid      (c_valid[0]),
      .out_ready      (c_ready[0]),
      .out_data       (c_data[0])
   );

   // row of cells: cell i does angle stage i and root digit i where those exist
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      ggs_cell #(
         .IDX     (i),
         .DO_ROT  (i < CSTG),
         .DO_SQRT (i < SQ_STEPS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c_valid[i]),
         .in_ready  (c_ready[i]),
         .in_data   (c_data[i]),
         .out_valid (c_valid[i+1]),
         .out_ready (c_ready[i+1]),
         .out_data  (c_data[i+1])
      );
   end

   // back end and output register
   ggs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (c_valid[NCELL]),
      .in_ready      (c_ready[NCELL]),
      .in_data       (c_data[NCELL]),
      .arrive_radius (radius_ff),
      .speed_gain    (gain_ff),
      .out_valid     (rsp_valid),
      .out_stall     (rsp_stall),
      .forward_speed (rsp_forward_speed),
      .turn_rate     (rsp_turn_rate),
      .arrived       (rsp_arrived)
   );

`ifndef SYNTHESIS
   // Input back-pressure only ever comes from a held result.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req stalled without a held result");

   // Arriving always means standing still.
   a_arrived_stop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_arrived) |-> (rsp_forward_speed == '0))
      else $error("arrived with nonzero speed");

   // Heading-only turn is always wrapped into plus or minus pi.
   a_arrived_wrap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_arrived) |->
         ((rsp_turn_rate <= 16'sd12868) && (rsp_turn_rate >= -16'sd12868)))
      else $error("arrived turn outside plus or minus pi");

   // Output valid can only rise after the last cell handed a beat on.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(c_valid[NCELL]) || $past(u_back.v1_ff)))
      else $error("result without a source beat");
`endif

endmodule

// ----- tb/go_to_goal_steering_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for go_to_goal_steering_top: directed poses, register sweeps, random traffic.
module go_to_goal_steering_top_tb;
   import ggs_pkg::*;

   // Stage count handed to the block; the predictor runs the same count, capped by the table.
   localparam int N_STAGES = CORDIC_STAGES_DEF;
   // Pipeline depth from the block header, plus margin for drop-outs while disabled.
   localparam int LATENCY  = ((N_STAGES > 24 ? 24 : N_STAGES) > 17 ?
                              (N_STAGES > 24 ? 24 : N_STAGES) : 17) + 5;
   localparam int SETTLE   = LATENCY + 8;
   // Register slot past the end of the list; writes there must be ignored.
   localparam logic [CSR_IW-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic signed [PW-1:0] tx;
      logic signed [PW-1:0] ty;
      logic signed [HW-1:0] th;
      logic signed [PW-1:0] ox;
      logic signed [PW-1:0] oy;
      logic signed [HW-1:0] oh;
   } pose_type;

   typedef struct packed {
      logic [SW-1:0]        speed;
      logic signed [TW-1:0] turn;
      logic                 arrived;
   } steer_cmd_type;

   // ---------------------------------------------------------------------------------------
   // Clock, reset and DUT port drivers; every input known from time zero.
   // ---------------------------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [PW-1:0] req_target_x = '0;
   logic signed [PW-1:0] req_target_y = '0;
   logic signed [HW-1:0] req_target_heading = '0;
   logic signed [PW-1:0] req_own_x = '0;
   logic signed [PW-1:0] req_own_y = '0;
   logic signed [HW-1:0] req_own_heading = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [SW-1:0]        rsp_forward_speed;
   logic signed [TW-1:0] rsp_turn_rate;
   logic                 rsp_arrived;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IW-1:0]    csr_index = '0;
   logic [15:0]          csr_data = '0;

   // Register mirror, matching the block's reset values.
   logic                 cfg_enable = ENABLE_RST;
   logic [15:0]          cfg_radius = RADIUS_RST;
   logic [GW-1:0]        cfg_gain   = GAIN_RST;

   // Expected commands, oldest first, and run bookkeeping.
   steer_cmd_type        pending_cmds[$];
   int                   req_gap_pct   = 0;
   int                   rsp_stall_pct = 0;
   int                   fail_count    = 0;
   int                   poses_sent    = 0;
   int                   cmds_checked  = 0;
   int                   arrived_seen  = 0;
   int                   speed_limited = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   go_to_goal_steering_top #(
      .CORDIC_STAGES(N_STAGES)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_target_x       (req_target_x),
      .req_target_y       (req_target_y),
      .req_target_heading (req_target_heading),
      .req_own_x          (req_own_x),
      .req_own_y          (req_own_y),
      .req_own_heading    (req_own_heading),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_forward_speed  (rsp_forward_speed),
      .rsp_turn_rate      (rsp_turn_rate),
      .rsp_arrived        (rsp_arrived),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // ---------------------------------------------------------------------------------------
   // Steering predictor
   // ---------------------------------------------------------------------------------------

   // Exact floor square root, digit by digit (radicand stays below 2^36).
   function automatic longint root_floor(longint n);
      longint root, bitv;
      root = 0;
      bitv = longint'(1) <<< 40;
      while (bitv > n) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    = n - root - bitv;
            root = (root >>> 1) + bitv;
         end else begin
            root = root >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return root;
   endfunction

   // CORDIC vectoring bearing in Q3.12; arithmetic shifts on longint are floor shifts.
   function automatic longint bearing_q12(longint dx, longint dy);
      longint cx, cy, ang, sx, sy, tmp;
      if (dx == 0 && dy == 0) return 0;
      cx  = dx * 16384;
      cy  = dy * 16384;
      ang = 0;
      // Left half plane: pre-rotate by a quarter turn toward the right half.
      if (cx < 0) begin
         if (cy >= 0) begin
            tmp = cx; cx = cy;  cy = -tmp; ang = longint'(HALF_PI_Q20);
         end else begin
            tmp = cx; cx = -cy; cy = tmp;  ang = -longint'(HALF_PI_Q20);
         end
      end
      for (int k = 0; k < N_STAGES && k < ATAN_LEN; k++) begin
         sx = cx >>> k;
         sy = cy >>> k;
         if (cy >= 0) begin
            cx = cx + sy; cy = cy - sx; ang = ang + longint'(ATAN_Q20[k]);
         end else begin
            cx = cx - sy; cy = cy + sx; ang = ang - longint'(ATAN_Q20[k]);
         end
      end
      return (ang + 128) >>> 8;
   endfunction

   // Single wrap into +-pi; larger errors stay partly out of range on purpose.
   function automatic longint wrap_once(longint e);
      if (e > longint'(PI_Q12))  return e - longint'(TWO_PI_Q12);
      if (e < -longint'(PI_Q12)) return e + longint'(TWO_PI_Q12);
      return e;
   endfunction

   function automatic steer_cmd_type predict_command(pose_type p);
      steer_cmd_type c;
      longint        dx, dy, reach, spd, err;
      dx    = longint'(p.tx) - longint'(p.ox);
      dy    = longint'(p.ty) - longint'(p.oy);
      reach = root_floor(dx * dx + dy * dy);
      c.arrived = (reach < longint'(cfg_radius));
      if (c.arrived) begin
         spd = 0;
         err = longint'(p.th) - longint'(p.oh);
      end else begin
         spd = (longint'(cfg_gain) * reach) >>> 8;
         if (spd > 65535) spd = 65535;
         err = bearing_q12(dx, dy) - longint'(p.oh);
      end
      err     = wrap_once(err);
      c.speed = spd[SW-1:0];
      c.turn  = err[TW-1:0];
      return c;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Result checker: every accepted rsp beat against the oldest expectation.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      steer_cmd_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cmds.size() == 0) begin
            $error("unexpected rsp beat: speed %0d turn %0d arrived %0d",
                   rsp_forward_speed, rsp_turn_rate, rsp_arrived);
            fail_count++;
         end else begin
            want = pending_cmds.pop_front();
            cmds_checked++;
            if (want.arrived) arrived_seen++;
            if (want.speed == '1) speed_limited++;
            if (rsp_forward_speed !== want.speed) begin
               $error("forward_speed expected %0d got %0d", want.speed, rsp_forward_speed);
               fail_count++;
            end
            if (rsp_turn_rate !== want.turn) begin
               $error("turn_rate expected %0d got %0d", want.turn, rsp_turn_rate);
               fail_count++;
            end
            if (rsp_arrived !== want.arrived) begin
               $error("arrived expected %0d got %0d", want.arrived, rsp_arrived);
               fail_count++;
            end
         end
      end
   end

   // Receiver back-pressure, random per cycle at the current rate.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // ---------------------------------------------------------------------------------------
   // Shared driving tasks
   // ---------------------------------------------------------------------------------------

   // One req beat: optional random gap, then hold the pose until the block takes it.
   task automatic send_pose(input pose_type p);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_target_x       <= p.tx;
      req_target_y       <= p.ty;
      req_target_heading <= p.th;
      req_own_x          <= p.ox;
      req_own_y          <= p.oy;
      req_own_heading    <= p.oh;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      poses_sent++;
      if (cfg_enable) pending_cmds.push_back(predict_command(p));
   endtask

   // Stop sending and wait for every expected command; with settle, also let dropped
   // beats clear the pipeline before a register write.
   task automatic wait_for_results(input bit settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_cmds.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_ENABLE: cfg_enable = val[0];
         CSR_RADIUS: cfg_radius = val;
         CSR_GAIN:   cfg_gain   = val[GW-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [15:0] en, input logic [15:0] rad,
                                input logic [15:0] gain);
      wait_for_results(1'b1);
      write_reg(CSR_ENABLE, en);
      write_reg(CSR_RADIUS, rad);
      write_reg(CSR_GAIN, gain);
   endtask

   function automatic pose_type make_pose(int tx, int ty, int th, int ox, int oy, int oh);
      pose_type p;
      p.tx = tx[PW-1:0];
      p.ty = ty[PW-1:0];
      p.th = th[HW-1:0];
      p.ox = ox[PW-1:0];
      p.oy = oy[PW-1:0];
      p.oh = oh[HW-1:0];
      return p;
   endfunction

   // Mix of full-range poses, near misses around the radius, headings within +-pi, axis offsets and zero offsets.
   function automatic pose_type random_pose();
      pose_type    p;
      int unsigned pick;
      int          span, d, h;
      pick = $urandom_range(9);
      p.tx = PW'($urandom());
      p.ty = PW'($urandom());
      p.th = HW'($urandom());
      p.ox = PW'($urandom());
      p.oy = PW'($urandom());
      p.oh = HW'($urandom());
      case (pick)
         4, 5, 6: begin
            span = (pick == 4) ? 40 : 1500;
            d    = int'($urandom_range(2 * span)) - span;
            p.ox = p.tx - d[PW-1:0];
            d    = int'($urandom_range(2 * span)) - span;
            p.oy = p.ty - d[PW-1:0];
         end
         7: begin
            // headings kept within +-pi
            h    = int'($urandom_range(TWO_PI_Q12)) - int'(PI_Q12);
            p.th = h[HW-1:0];
            h    = int'($urandom_range(TWO_PI_Q12)) - int'(PI_Q12);
            p.oh = h[HW-1:0];
         end
         8: begin
            if ($urandom_range(1)) p.ox = p.tx;
            else p.oy = p.ty;
         end
         9: begin
            p.ox = p.tx;
            p.oy = p.ty;
         end
         default: ;
      endcase
      return p;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Out of reset the output is off: beats are taken and dropped.
   task automatic test_disabled_after_reset();
      repeat (6) send_pose(random_pose());
      wait_for_results(1'b1);
      write_reg(CSR_ENABLE, 16'd1);
   endtask

   // Reset radius and gain: arrive threshold, heading wraps, quadrants, full-scale offsets.
   task automatic test_default_registers();
      send_pose(make_pose(0, 0, 0, 0, 0, 0));                    // zero offset, arrived
      send_pose(make_pose(24, 10, 0, 0, 0, 0));                  // exactly at radius
      send_pose(make_pose(25, 0, 12868, 0, 0, -12868));          // just inside, +2pi wrap
      send_pose(make_pose(0, 0, 16383, 0, 0, -16384));           // headings past pi
      send_pose(make_pose(0, 0, -16384, 0, 0, 16383));
      send_pose(make_pose(0, 0, 12868, 0, 0, 0));                // error exactly pi
      send_pose(make_pose(0, 0, -12868, 0, 0, 1));               // just below -pi
      send_pose(make_pose(32767, 32767, 0, -32768, -32768, -16384));
      send_pose(make_pose(-32768, 0, 0, 32767, 0, 16383));       // left half, y zero
      send_pose(make_pose(-32768, -1, 0, 32767, 0, 0));          // left half, y negative
      send_pose(make_pose(0, 500, 0, 0, 0, 0));                  // straight up
      send_pose(make_pose(0, -500, 0, 0, 0, 0));                 // straight down
      send_pose(make_pose(-300, -400, 0, 0, 0, -12868));
      send_pose(make_pose(32767, -32768, 0, -32768, 32767, 12868));
   endtask

   // Register extremes: saturating speed, huge and zero radius, zero gain.
   task automatic test_register_extremes();
      apply_setting(16'd1, 16'hFFFF, 16'h01FF);
      send_pose(make_pose(32767, 0, 0, -32768, 0, 0));           // reach == radius
      send_pose(make_pose(32766, 0, 100, -32768, 0, -100));      // one below radius
      send_pose(make_pose(32767, 32767, 0, -32768, -32768, 0));
      apply_setting(16'd1, 16'd0, 16'd0);
      send_pose(make_pose(77, -5, 0, 77, -5, 16383));            // zero offset, zero radius
      send_pose(make_pose(1, 0, 0, 0, 0, 0));
      apply_setting(16'd1, 16'd0, 16'h01FF);
      send_pose(make_pose(1, 0, 0, 0, 0, 0));
      send_pose(make_pose(-1, 0, 0, 0, 0, -16384));
   endtask

   // A write past the register list must leave all settings alone.
   task automatic test_spare_index();
      wait_for_results(1'b1);
      write_reg(CSR_SPARE, 16'hFFFF);
      send_pose(make_pose(3, 0, 0, 0, 0, 0));
   endtask

   // Random settings and poses at one idle mix, with a pause mid-batch and a disabled batch.
   task automatic test_random_traffic(input int gap_pct, input int stall_pct);
      logic [15:0] rad, gain_data;
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      for (int s = 0; s < 4; s++) begin
         case ($urandom_range(3))
            0: rad = 16'd0;
            1: rad = 16'hFFFF;
            2: rad = 16'($urandom_range(3000));
            default: rad = 16'($urandom());
         endcase
         case ($urandom_range(3))
            0: gain_data = 16'd0;
            1: gain_data = 16'h01FF;
            2: gain_data = 16'($urandom());
            default: gain_data = 16'd128;
         endcase
         apply_setting(16'd1, rad, gain_data);
         for (int n = 0; n < 155; n++) begin
            send_pose(random_pose());
            if (n == 77) wait_for_results(1'b0);   // sender holds off until all caught up
         end
      end
      apply_setting(16'd0, rad, gain_data);
      repeat (8) send_pose(random_pose());
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled_after_reset();
      test_default_registers();
      test_register_extremes();
      test_spare_index();
      test_random_traffic(15, 78);
      test_random_traffic(78, 15);
      test_random_traffic(0, 0);

      wait_for_results(1'b1);
      $display("%0d poses sent, %0d commands checked (%0d arrived, %0d at the speed limit)",
               poses_sent, cmds_checked, arrived_seen, speed_limited);
      $display("register extremes, disabled output and three idle mixes were exercised");
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/ggs_pkg.sv
hdl/ggs_front.sv
hdl/ggs_cell.sv
hdl/ggs_back.sv
hdl/go_to_goal_steering_top.sv
tb/go_to_goal_steering_top_tb.sv
